[rtl/cdq_pkg.sv]
`default_nettype none
package cdq_pkg;

  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 4;
  localparam int FIELD_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_PEEK_REAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // what the controller decided for one request, minus the read data
  typedef struct packed {
    logic                rd;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
  } resp_t;

endpackage
`default_nettype wire

[rtl/cdq_ram.sv]
`default_nettype none
module cdq_ram #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
  localparam int PTR_W     = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic                  re,
  input  wire logic [PTR_W-1:0]      addr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/cdq_ctrl.sv]
`default_nettype none
module cdq_ctrl #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
  localparam int PTR_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 req_go,
  input  wire logic [cdq_pkg::OPCODE_W-1:0]         req_opcode,
  input  wire logic signed [cdq_pkg::FIELD_W-1:0]   req_value,
  output logic                                      mem_we,
  output logic                                      mem_re,
  output logic [PTR_W-1:0]                          mem_addr,
  output logic [DATA_WIDTH-1:0]                     mem_wdata,
  output cdq_pkg::resp_t                            resp
);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full, empty;
  logic             we_int, re_int;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    we_int      = 1'b0;
    re_int      = 1'b0;
    mem_addr    = head_r;
    resp.rd     = 1'b0;
    resp.status = cdq_pkg::ST_OK;
    unique case (req_opcode) inside
      cdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          resp.status = cdq_pkg::ST_FULL;
        end else begin
          head_nxt  = ring_prev(head_r);
          mem_addr  = head_nxt;
          we_int    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      cdq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          resp.status = cdq_pkg::ST_FULL;
        end else begin
          mem_addr  = tail_r;
          tail_nxt  = ring_next(tail_r);
          we_int    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          resp.status = cdq_pkg::ST_EMPTY;
        end else begin
          mem_addr = head_r;
          re_int   = 1'b1;
          resp.rd  = 1'b1;
          if (req_opcode == cdq_pkg::OP_POP_FRONT) begin
            head_nxt  = ring_next(head_r);
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      cdq_pkg::OP_POP_REAR, cdq_pkg::OP_PEEK_REAR: begin
        if (empty) begin
          resp.status = cdq_pkg::ST_EMPTY;
        end else begin
          mem_addr = ring_prev(tail_r);
          re_int   = 1'b1;
          resp.rd  = 1'b1;
          if (req_opcode == cdq_pkg::OP_POP_REAR) begin
            tail_nxt  = ring_prev(tail_r);
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
    resp.occ = cdq_pkg::OCC_W'(count_nxt);
  end

  assign mem_we    = we_int & req_go;
  assign mem_re    = re_int & req_go;
  // sign-extend the 32-bit word, then keep the stored width
  assign mem_wdata = DATA_WIDTH'(64'(req_value));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (req_go) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/circular_deque.sv]
`default_nettype none
// Double-ended queue of DEPTH words in a ring held in one synchronous RAM.
// A request (push or pop at either end, or a peek) can be taken every clock
// while in_stall is low. The RAM read happens at the accepting edge, and the
// output registers load once the output is free. Each request reads or writes
// at most one RAM word at its single port, which sets the one-per-cycle rate.
// While a result waits on a stalled output, one more request is taken and
// then the input stalls.
// Pushes to a full deque and pops or peeks on an empty one are refused and
// report status. The RAM needs no clearing after reset, since only words that
// were pushed are ever read.
module circular_deque #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [cdq_pkg::OPCODE_W-1:0]       in_opcode,
  input  wire logic signed [cdq_pkg::FIELD_W-1:0] in_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [cdq_pkg::FIELD_W-1:0]      out_data,
  output logic [cdq_pkg::STATUS_W-1:0]            out_status,
  output logic [cdq_pkg::OCC_W-1:0]               out_occupancy
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                  in_go;
  logic                  out_free;
  logic                  mem_we, mem_re;
  logic [PTR_W-1:0]      mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  logic signed [DATA_WIDTH-1:0] rd_s;
  cdq_pkg::resp_t        resp;

  logic                  pend_r, pend_nxt;
  cdq_pkg::resp_t        pend_info_r;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [cdq_pkg::FIELD_W-1:0] out_data_r;
  logic [cdq_pkg::STATUS_W-1:0]       out_status_r;
  logic [cdq_pkg::OCC_W-1:0]          out_occ_r;

  assign out_free = ~out_valid_r | ~out_stall;
  // the ram read data holds only while no new read is accepted
  assign in_stall = pend_r & ~out_free;
  assign in_go    = in_valid & ~in_stall;

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_go     (in_go),
    .req_opcode (in_opcode),
    .req_value  (in_value),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .resp       (resp)
  );

  cdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign rd_s          = mem_rdata;
  assign pend_nxt      = in_go | (pend_r & ~out_free);
  assign out_valid_nxt = out_free ? pend_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      pend_info_r <= resp;
    end
    if (out_free && pend_r) begin
      out_data_r   <= pend_info_r.rd ? cdq_pkg::FIELD_W'(64'(rd_s)) : '0;
      out_status_r <= pend_info_r.status;
      out_occ_r    <= pend_info_r.occ;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  a_full_occ : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cdq_pkg::ST_FULL
      |-> out_occupancy == cdq_pkg::OCC_W'(DEPTH) && out_data == '0)
    else $error("refused push without a full deque");

  a_empty_occ : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cdq_pkg::ST_EMPTY
      |-> out_occupancy == '0 && out_data == '0)
    else $error("refused pop or peek without an empty deque");

  a_no_accept_held : assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_valid && out_stall |-> in_stall)
    else $error("request accepted while read data is still pending");

endmodule
`default_nettype wire
